/* sv/stable_priority_queue_assert.svh */
// assertion macros for the stable priority queue
// used by the top level; depends on a clk and rst in the including scope
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// checked only outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/spq_pkg.sv */
// shared types and constants for the stable priority queue
// no dependencies
package spq_pkg;

  localparam int NAME_W        = 24;
  localparam int PRIO_W        = 8;
  localparam int OCC_W         = 5;
  localparam int DEPTH_DEF     = 16;
  localparam int PRIO_BITS_DEF = 8;

  typedef enum logic {
    ACT_INSERT  = 1'b0,
    ACT_EXECUTE = 1'b1
  } action_t;

  // command word
  typedef struct packed {
    action_t             action;
    logic [NAME_W-1:0]   proc_name;
    logic [PRIO_W-1:0]   priority_req;
  } cmd_word_t;

  // result word
  typedef struct packed {
    logic                popped_valid;
    logic [NAME_W-1:0]   popped_name;
    logic [PRIO_W-1:0]   popped_priority;
    logic                underflow;
    logic                overflow;
    logic [OCC_W-1:0]    occupancy;
  } res_word_t;

  // per-cycle operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } spq_op_t;

endpackage

/* sv/spq_cell.sv */
// one slot of the sorted shift chain: holds an entry and trades with its neighbors
// depends on spq_pkg
module spq_cell import spq_pkg::*; #(
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                 clk,
  input  spq_op_t              op,
  input  logic [NAME_W-1:0]    new_name,
  input  logic [PRIO_BITS-1:0] new_prio,
  input  logic                 occ,
  input  logic                 at_prev,
  input  logic [NAME_W-1:0]    prev_name,
  input  logic [PRIO_BITS-1:0] prev_prio,
  input  logic [NAME_W-1:0]    next_name,
  input  logic [PRIO_BITS-1:0] next_prio,
  output logic                 at,
  output logic [NAME_W-1:0]    name,
  output logic [PRIO_BITS-1:0] prio
);

  // this slot is at or past the insert point: empty, or strictly lower priority
  assign at = occ ? (prio < new_prio) : 1'b1;

  // shift toward head on pop, away from head on insert
  always_ff @(posedge clk) begin
    if (op.pop) begin
      name <= next_name;
      prio <= next_prio;
    end else if (op.ins && at) begin
      if (!at_prev) begin
        name <= new_name;
        prio <= new_prio;
      end else begin
        name <= prev_name;
        prio <= prev_prio;
      end
    end
  end

endmodule

/* sv/stable_priority_queue.sv */
// Stable priority queue built as a chain of compare-and-shift cells.
// Command channel: cmd_valid / cmd_stall / cmd. A word is taken at a rising
// edge with cmd_valid high and cmd_stall low. An insert places the entry
// behind every stored entry of equal or higher priority; an execute removes
// the head entry.
// Result channel: res_valid / res_stall / res. Exactly one result word per
// command word, held steady while res_stall is high.
// The result is registered and shows in the cycle after acceptance.
// Throughput: one command per cycle while no result is stalled; every cell
// compares its priority with the incoming one in parallel and shifts in the
// same edge, so the only limit is the single result register.
// When the receiver stalls with a result waiting, cmd_stall goes high in the
// same cycle and no further command is taken until the result leaves.
// Reset (synchronous, rst high) empties the queue and drops any pending
// result; slot contents are not cleared and are only read once written.
// Insert into a full queue is refused with overflow set; execute on an
// empty queue reports underflow.
module stable_priority_queue import spq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_word_t cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output res_word_t res
);

  `include "stable_priority_queue_assert.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 is_ins;
  spq_op_t              op;
  logic [NAME_W-1:0]    new_name;
  logic [PRIO_BITS-1:0] new_prio;
  logic [PRIO_BITS+PRIO_W-1:0] in_prio_wide;
  logic [PRIO_W+PRIO_BITS-1:0] head_prio_wide;
  logic [OCC_W+CNT_W-1:0]      occ_wide;

  logic [DEPTH-1:0]     occ;
  logic [DEPTH-1:0]     at;
  logic [NAME_W-1:0]    cell_name [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];

  res_word_t            res_next;

  // handshake and command decode
  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign is_ins    = (cmd.action == ACT_INSERT);
  assign op.ins    = accept && is_ins && !full;
  assign op.pop    = accept && !is_ins && !empty;
  assign new_name  = cmd.proc_name;

  // fit incoming priority to the stored width
  assign in_prio_wide = {{PRIO_BITS{1'b0}}, cmd.priority_req};
  assign new_prio     = in_prio_wide[PRIO_BITS-1:0];

  // the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 at_prev;
    logic [NAME_W-1:0]    prev_name;
    logic [PRIO_BITS-1:0] prev_prio;
    logic [NAME_W-1:0]    next_name;
    logic [PRIO_BITS-1:0] next_prio;

    assign occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign at_prev   = 1'b0;
      assign prev_name = new_name;
      assign prev_prio = new_prio;
    end else begin : g_body
      assign at_prev   = at[i-1];
      assign prev_name = cell_name[i-1];
      assign prev_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_name = cell_name[i];
      assign next_prio = cell_prio[i];
    end else begin : g_mid
      assign next_name = cell_name[i+1];
      assign next_prio = cell_prio[i+1];
    end

    spq_cell #(
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .new_name  (new_name),
      .new_prio  (new_prio),
      .occ       (occ[i]),
      .at_prev   (at_prev),
      .prev_name (prev_name),
      .prev_prio (prev_prio),
      .next_name (next_name),
      .next_prio (next_prio),
      .at        (at[i]),
      .name      (cell_name[i]),
      .prio      (cell_prio[i])
    );
  end

  // occupancy counter
  always_comb begin
    count_next = count;
    if (op.ins) begin
      count_next = count + 1'b1;
    end else if (op.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result word
  assign head_prio_wide = {{PRIO_W{1'b0}}, cell_prio[0]};
  assign occ_wide       = {{OCC_W{1'b0}}, count_next};

  always_comb begin
    res_next                 = '0;
    res_next.popped_valid    = op.pop;
    res_next.popped_name     = op.pop ? cell_name[0] : '0;
    res_next.popped_priority = op.pop ? head_prio_wide[PRIO_W-1:0] : '0;
    res_next.underflow       = !is_ins && empty;
    res_next.overflow        = is_ins && full;
    res_next.occupancy       = occ_wide[OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  // checks
  `SPQ_ASSERT(a_count_bound, (count <= CNT_W'(DEPTH)), "occupancy beyond depth")
  `SPQ_ASSERT(a_ins_count, (op.ins) |=> (count == $past(count) + 1'b1), "insert lost count")
  `SPQ_ASSERT(a_sorted_head, (count >= 2) |-> (cell_prio[0] >= cell_prio[1]), "head out of order")
  `SPQ_ASSERT_ALWAYS(a_reset_idle, rst |=> !res_valid, "result after reset")

endmodule
